>>> hw/rtl/pitch_track_note_merger_top_assert.svh
// assertion macros shared by the note merger
`ifndef PITCH_TRACK_NOTE_MERGER_TOP_ASSERT_SVH
`define PITCH_TRACK_NOTE_MERGER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PTNM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("note merger check failed");

// next-cycle implication, disabled during reset
`define PTNM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("note merger check failed");

`endif

>>> hw/rtl/ptnm_pkg.sv
package ptnm_pkg;

  localparam int FREQ_W = 13;
  localparam int NOTE_W = 7;
  localparam int HOP_W  = 10;
  localparam int RUN_W  = 20;
  localparam int CNT_W  = 4;
  localparam int JIT_W  = 7;
  localparam int PROD_W = 20;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [RUN_W-1:0] RUN_DUR_MAX  = 20'hFFFFF;
  localparam logic [CNT_W-1:0] PEND_CNT_MAX = 4'd15;
  localparam logic [6:0]       PCT_SCALE    = 7'd100;

  localparam logic [CNT_W-1:0] HOLD_RST    = 4'd4;
  localparam logic [CNT_W-1:0] CONFIRM_RST = 4'd1;
  localparam logic [JIT_W-1:0] JITTER_RST  = 7'd8;

  // register indexes, byte address 4*i
  localparam logic [1:0] REG_HOLD    = 2'd0;
  localparam logic [1:0] REG_CONFIRM = 2'd1;
  localparam logic [1:0] REG_JITTER  = 2'd2;

  localparam int RESULT_DEPTH = 4;

  typedef struct packed {
    logic              voiced;
    logic              fallback;
    logic [FREQ_W-1:0] freq;
    logic [NOTE_W-1:0] note;
    logic [HOP_W-1:0]  dur;
    logic              eos;
  } hop_t;

  typedef struct packed {
    logic [CNT_W-1:0] hold;
    logic [CNT_W-1:0] confirm;
    logic [JIT_W-1:0] jitter;
  } cfg_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [RUN_W-1:0]  dur;
    logic              last;
  } res_t;

endpackage

>>> hw/rtl/ptnm_cfg.sv
module ptnm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptnm_pkg::ADDR_W-1:0] paddr,
  input  logic [ptnm_pkg::DATA_W-1:0] pwdata,
  output logic [ptnm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output ptnm_pkg::cfg_t              cfg
);

  ptnm_pkg::cfg_t cfg_r;
  logic [1:0]     idx;
  logic           wr;

  assign idx    = paddr[ptnm_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold    <= ptnm_pkg::HOLD_RST;
      cfg_r.confirm <= ptnm_pkg::CONFIRM_RST;
      cfg_r.jitter  <= ptnm_pkg::JITTER_RST;
    end else if (wr) begin
      unique case (idx)
        ptnm_pkg::REG_HOLD:    cfg_r.hold    <= pwdata[ptnm_pkg::CNT_W-1:0];
        ptnm_pkg::REG_CONFIRM: cfg_r.confirm <= pwdata[ptnm_pkg::CNT_W-1:0];
        ptnm_pkg::REG_JITTER:  cfg_r.jitter  <= pwdata[ptnm_pkg::JIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ptnm_pkg::REG_HOLD:    prdata = ptnm_pkg::DATA_W'(cfg_r.hold);
      ptnm_pkg::REG_CONFIRM: prdata = ptnm_pkg::DATA_W'(cfg_r.confirm);
      ptnm_pkg::REG_JITTER:  prdata = ptnm_pkg::DATA_W'(cfg_r.jitter);
      default:               prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/ptnm_tracker.sv
module ptnm_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  ptnm_pkg::hop_t              hop,
  input  ptnm_pkg::cfg_t              cfg,
  output logic [ptnm_pkg::FREQ_W-1:0] pitch
);

  logic [ptnm_pkg::FREQ_W-1:0] sp_r, sp_nxt, pp_r, pp_nxt;
  logic [ptnm_pkg::NOTE_W-1:0] sn_r, sn_nxt, pn_r, pn_nxt;
  logic                        pv_r, pv_nxt;
  logic [ptnm_pkg::CNT_W-1:0]  pc_r, pc_nxt, mc_r, mc_nxt;

  logic [ptnm_pkg::FREQ_W-1:0] diff;
  logic [ptnm_pkg::PROD_W-1:0] lhs, rhs;
  logic                        jit_ok;
  logic                        do_hold;

  // deviation test: |f - ref| * 100 <= ref * jitter
  always_comb begin
    diff   = (hop.freq > sp_r) ? hop.freq - sp_r : sp_r - hop.freq;
    lhs    = ptnm_pkg::PROD_W'(diff) * ptnm_pkg::PROD_W'(ptnm_pkg::PCT_SCALE);
    rhs    = ptnm_pkg::PROD_W'(sp_r) * ptnm_pkg::PROD_W'(cfg.jitter);
    jit_ok = (hop.freq != '0) && (sp_r != '0) && (lhs <= rhs);
  end

  always_comb begin
    sp_nxt  = sp_r;
    sn_nxt  = sn_r;
    pp_nxt  = pp_r;
    pn_nxt  = pn_r;
    pv_nxt  = pv_r;
    pc_nxt  = pc_r;
    mc_nxt  = mc_r;
    do_hold = 1'b0;

    priority if (!hop.voiced || hop.freq == '0) begin
      do_hold = 1'b1;
    end else if (sp_r != '0 && (hop.note == sn_r || jit_ok)) begin
      mc_nxt = '0;
      pp_nxt = '0;
      pn_nxt = '0;
      pv_nxt = 1'b0;
      pc_nxt = '0;
    end else if (hop.fallback) begin
      do_hold = 1'b1;
    end else begin
      if (pv_r && hop.note == pn_r) begin
        if (pc_r < ptnm_pkg::PEND_CNT_MAX) pc_nxt = pc_r + 1'b1;
      end else begin
        pp_nxt = hop.freq;
        pn_nxt = hop.note;
        pv_nxt = 1'b1;
        pc_nxt = 4'd1;
      end
      // candidate confirmed
      if (pc_nxt >= cfg.confirm) begin
        sp_nxt = pp_nxt;
        sn_nxt = pn_nxt;
        mc_nxt = '0;
        pp_nxt = '0;
        pn_nxt = '0;
        pv_nxt = 1'b0;
        pc_nxt = '0;
      end
    end

    // hold the stable pitch or fall to silence
    if (do_hold) begin
      pp_nxt = '0;
      pn_nxt = '0;
      pv_nxt = 1'b0;
      pc_nxt = '0;
      if (sp_r != '0 && mc_r < cfg.hold) begin
        mc_nxt = mc_r + 1'b1;
      end else begin
        sp_nxt = '0;
        sn_nxt = '0;
        mc_nxt = '0;
      end
    end
  end

  assign pitch = sp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (en && hop.eos)) begin
      sp_r <= '0;
      sn_r <= '0;
      pp_r <= '0;
      pn_r <= '0;
      pv_r <= 1'b0;
      pc_r <= '0;
      mc_r <= '0;
    end else if (en) begin
      sp_r <= sp_nxt;
      sn_r <= sn_nxt;
      pp_r <= pp_nxt;
      pn_r <= pn_nxt;
      pv_r <= pv_nxt;
      pc_r <= pc_nxt;
      mc_r <= mc_nxt;
    end
  end

endmodule

>>> hw/rtl/ptnm_merger.sv
module ptnm_merger (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  ptnm_pkg::hop_t              hop,
  input  logic [ptnm_pkg::FREQ_W-1:0] pitch,
  output ptnm_pkg::res_t              res0,
  output ptnm_pkg::res_t              res1,
  output logic [1:0]                  push_n,
  output logic                        run_open
);

  logic [ptnm_pkg::FREQ_W-1:0] rf_r, rf_mrg;
  logic [ptnm_pkg::RUN_W-1:0]  rd_r, rd_mrg;
  logic                        rv_r, rv_mrg;
  logic [ptnm_pkg::RUN_W:0]    sum;
  logic                        close;
  ptnm_pkg::res_t              close_res, eos_res;

  always_comb begin
    rf_mrg = rf_r;
    rd_mrg = rd_r;
    rv_mrg = rv_r;
    close  = 1'b0;
    sum    = {1'b0, rd_r} + (ptnm_pkg::RUN_W + 1)'(hop.dur);
    if (hop.dur != '0) begin
      if (rv_r && rf_r == pitch) begin
        rd_mrg = sum[ptnm_pkg::RUN_W] ? ptnm_pkg::RUN_DUR_MAX : sum[ptnm_pkg::RUN_W-1:0];
      end else begin
        close  = rv_r;
        rf_mrg = pitch;
        rd_mrg = ptnm_pkg::RUN_W'(hop.dur);
        rv_mrg = 1'b1;
      end
    end
  end

  always_comb begin
    close_res.freq = rf_r;
    close_res.dur  = rd_r;
    close_res.last = 1'b0;
    eos_res.freq   = rv_mrg ? rf_mrg : '0;
    eos_res.dur    = rv_mrg ? rd_mrg : '0;
    eos_res.last   = 1'b1;
  end

  // a closed note always goes out ahead of the end-of-stream note
  assign res0     = close ? close_res : eos_res;
  assign res1     = eos_res;
  assign push_n   = en ? ({1'b0, close} + {1'b0, hop.eos}) : 2'd0;
  assign run_open = rv_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (en && hop.eos)) begin
      rf_r <= '0;
      rd_r <= '0;
      rv_r <= 1'b0;
    end else if (en) begin
      rf_r <= rf_mrg;
      rd_r <= rd_mrg;
      rv_r <= rv_mrg;
    end
  end

endmodule

>>> hw/rtl/ptnm_result_fifo.sv
module ptnm_result_fifo #(
  parameter int DEPTH = ptnm_pkg::RESULT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   push_n,
  input  ptnm_pkg::res_t               wdata0,
  input  ptnm_pkg::res_t               wdata1,
  input  logic                         pop,
  output ptnm_pkg::res_t               rdata,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  ptnm_pkg::res_t    mem [DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt, wp1, wp2, rp_r, rp_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wp1 = ptr_inc(wp_r);
  assign wp2 = ptr_inc(wp1);

  always_comb begin
    unique case (push_n)
      2'd0:    wp_nxt = wp_r;
      2'd1:    wp_nxt = wp1;
      default: wp_nxt = wp2;
    endcase
    rp_nxt    = pop ? ptr_inc(rp_r) : rp_r;
    level_nxt = level_r + LVL_W'(push_n) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp_r] <= wdata0;
    if (push_n == 2'd2) mem[wp1]  <= wdata1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      level_r <= level_nxt;
    end
  end

  assign rdata = mem[rp_r];
  assign level = level_r;

endmodule

>>> hw/rtl/pitch_track_note_merger_top.sv
// Pitch-track note merger: takes one pitch-detector hop per transfer and turns the
// stream into finished notes (frequency, saturating duration, last flag). Hops are
// accepted one per cycle while in_stall is low; each hop is captured in an input
// register, then handled by the tracker and merger once the fifo has room. A hop
// yields zero, one or two notes (a closed note and, on end of stream, the flushed
// or empty final note); notes queue in a small result fifo (RESULT_DEPTH entries)
// that drains one transfer per cycle while out_stall is low, and the input stalls
// only while that fifo has fewer than two free entries. Sustained rate is one hop
// per cycle as long as hops average at most one note each and out_stall stays low. The
// registers sit on an APB-style port at byte addresses 0 (hold_hops),
// 4 (confirm_hops) and 8 (jitter_percent); write them only while the block is idle.
`include "pitch_track_note_merger_top_assert.svh"

module pitch_track_note_merger_top #(
  parameter int RESULT_DEPTH = ptnm_pkg::RESULT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,

  // hop input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_voiced,
  input  logic                        in_fallback,
  input  logic [ptnm_pkg::FREQ_W-1:0] in_detected_frequency,
  input  logic [ptnm_pkg::NOTE_W-1:0] in_detected_note,
  input  logic [ptnm_pkg::HOP_W-1:0]  in_hop_duration_ms,
  input  logic                        in_end_of_stream,

  // note output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ptnm_pkg::FREQ_W-1:0] out_note_frequency,
  output logic [ptnm_pkg::RUN_W-1:0]  out_note_duration_ms,
  output logic                        out_last,

  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptnm_pkg::ADDR_W-1:0] paddr,
  input  logic [ptnm_pkg::DATA_W-1:0] pwdata,
  output logic [ptnm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int LVL_W = $clog2(RESULT_DEPTH + 1);

  ptnm_pkg::cfg_t              cfg;
  ptnm_pkg::hop_t              hop_in, hop_r;
  logic                        s1_valid_r, s1_valid_nxt;
  logic                        in_xfer, out_xfer;
  logic                        room, advance;
  logic [ptnm_pkg::FREQ_W-1:0] pitch;
  ptnm_pkg::res_t              res0, res1, head;
  logic [1:0]                  push_n;
  logic                        run_open;
  logic [LVL_W-1:0]            level;

  // register block
  ptnm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // gather the input fields
  always_comb begin
    hop_in.voiced   = in_voiced;
    hop_in.fallback = in_fallback;
    hop_in.freq     = in_detected_frequency;
    hop_in.note     = in_detected_note;
    hop_in.dur      = in_hop_duration_ms;
    hop_in.eos      = in_end_of_stream;
  end

  // a hop may only leave the input register when two fifo slots are free,
  // since it can produce two notes
  assign room     = level <= LVL_W'(RESULT_DEPTH - 2);
  assign advance  = s1_valid_r && room;
  assign in_stall = s1_valid_r && !room;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer)      s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) hop_r <= hop_in;
  end

  // pitch smoothing: stable / pending / hold state
  ptnm_tracker u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .hop   (hop_r),
    .cfg   (cfg),
    .pitch (pitch)
  );

  // run-length merge of smoothed pitch into notes
  ptnm_merger u_merger (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .hop      (hop_r),
    .pitch    (pitch),
    .res0     (res0),
    .res1     (res1),
    .push_n   (push_n),
    .run_open (run_open)
  );

  // result queue, one note per output transfer
  assign out_valid = level != '0;
  assign out_xfer  = out_valid && !out_stall;

  ptnm_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .wdata0 (res0),
    .wdata1 (res1),
    .pop    (out_xfer),
    .rdata  (head),
    .level  (level)
  );

  assign out_note_frequency   = head.freq;
  assign out_note_duration_ms = head.dur;
  assign out_last             = head.last;

  // fifo never holds more notes than it has entries
  `PTNM_ASSERT_IMPL(a_level_bound, 1'b1, level <= LVL_W'(RESULT_DEPTH))
  // end of stream always leaves a final note waiting
  `PTNM_ASSERT_NEXT(a_eos_emits, advance && hop_r.eos, out_valid)
  // end of stream closes the open run
  `PTNM_ASSERT_NEXT(a_eos_clears_run, advance && hop_r.eos, !run_open)

endmodule
